/* rtl/core/rsp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsp_pkg
// Types and constants shared by the run-length sprite pixel lookup block.
// ----------------------------------------------------------------------------
package rsp_pkg;

  localparam int STORE_BYTES_DEF = 65536;
  localparam int MAX_REGIONS_DEF = 64;
  localparam int REGION_IDX_W    = 6;
  localparam int REGION_SLOTS    = 2 ** REGION_IDX_W;

  localparam int RUN_TRANSPARENT_BIT = 7;
  localparam logic [6:0] RUN_MASK    = 7'h7F;

  typedef enum logic [1:0] {
    CMD_STORE_WRITE  = 2'd0,
    CMD_REGION_WRITE = 2'd1,
    CMD_QUERY        = 2'd2,
    CMD_NONE         = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_BAD_REGION  = 2'd1,
    ST_BAD_COORD   = 2'd2,
    ST_BAD_DATA    = 2'd3
  } status_t;

  typedef struct packed {
    cmd_t        command;
    logic [15:0] store_address;
    logic [7:0]  store_byte;
    logic [5:0]  region_index;
    logic [10:0] region_width;
    logic [10:0] region_height;
    logic [15:0] region_offset;
    logic [9:0]  pos_x;
    logic [9:0]  pos_y;
  } item_t;

  typedef struct packed {
    logic [7:0] pixel;
    status_t    status;
  } result_t;

  typedef struct packed {
    logic [10:0] width;
    logic [10:0] height;
    logic [15:0] offset;
  } region_t;

endpackage

/* rtl/core/rle_sprite_pixel_lookup_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rle_sprite_pixel_lookup_unit
// Run-length sprite store with region table and per-pixel lookup walk.
//
//   channel   signals                 transfer
//   command   start, busy, item       start high while busy low
//   result    done, result            done high, one cycle, always taken
//   config    cfg_we, cfg_wdata       cfg_we high
//
// store write: address reduced by STORE_BYTES in S_WRAP until in range
// region write: in S_IDLE; bad region query: result the cycle after transfer
// other queries: S_RLOAD, then S_WALK per coded byte walked, then S_PIXEL
//   for a literal pixel fetch; the walk reads one store byte per cycle through the
//   shared pointer adder
// synchronous reset clears the sequencer and region_count; store and table
//   hold no reset value
// ----------------------------------------------------------------------------
module rle_sprite_pixel_lookup_unit #(
  parameter int STORE_BYTES = rsp_pkg::STORE_BYTES_DEF,
  parameter int MAX_REGIONS = rsp_pkg::MAX_REGIONS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  rsp_pkg::item_t   item,
  output logic             done,
  output rsp_pkg::result_t result,
  input  logic             cfg_we,
  input  logic [6:0]       cfg_wdata
);

  import rsp_pkg::*;

  localparam int AW  = $clog2(STORE_BYTES);
  localparam int PW  = ((AW > 16) ? AW : 16) + 1;
  localparam int RD  = (MAX_REGIONS < REGION_SLOTS) ? MAX_REGIONS : REGION_SLOTS;
  localparam int RIW = (RD > 1) ? $clog2(RD) : 1;

  logic          store_we;
  logic [AW-1:0] store_waddr;
  logic [7:0]    store_wdata;
  logic [AW-1:0] store_raddr;
  logic [7:0]    store_rdata;
  logic          tab_we;
  logic [RIW-1:0] tab_addr;
  region_t       tab_wdata;
  region_t       tab_rdata;
  logic [PW-1:0] alu_a;
  logic [PW-1:0] alu_b;
  logic          alu_sub;
  logic [PW:0]   alu_sum;
  logic          alu_over;

  rsp_ram #(
    .WIDTH (8),
    .DEPTH (STORE_BYTES),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .we    (store_we),
    .waddr (store_waddr),
    .wdata (store_wdata),
    .raddr (store_raddr),
    .rdata (store_rdata)
  );

  rsp_ram #(
    .WIDTH ($bits(region_t)),
    .DEPTH (RD),
    .AW    (RIW)
  ) u_regions (
    .clk   (clk),
    .we    (tab_we),
    .waddr (tab_addr),
    .wdata (tab_wdata),
    .raddr (tab_addr),
    .rdata (tab_rdata)
  );

  rsp_alu #(
    .PW          (PW),
    .STORE_BYTES (STORE_BYTES)
  ) u_alu (
    .a    (alu_a),
    .b    (alu_b),
    .sub  (alu_sub),
    .sum  (alu_sum),
    .over (alu_over)
  );

  rsp_ctrl #(
    .STORE_BYTES (STORE_BYTES),
    .MAX_REGIONS (MAX_REGIONS),
    .AW          (AW),
    .PW          (PW),
    .RIW         (RIW)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .item        (item),
    .done        (done),
    .result      (result),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .store_we    (store_we),
    .store_waddr (store_waddr),
    .store_wdata (store_wdata),
    .store_raddr (store_raddr),
    .store_rdata (store_rdata),
    .tab_we      (tab_we),
    .tab_addr    (tab_addr),
    .tab_wdata   (tab_wdata),
    .tab_rdata   (tab_rdata),
    .alu_a       (alu_a),
    .alu_b       (alu_b),
    .alu_sub     (alu_sub),
    .alu_sum     (alu_sum),
    .alu_over    (alu_over)
  );

endmodule

/* rtl/core/rsp_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsp_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module rsp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

/* rtl/core/rsp_alu.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsp_alu
// Shared pointer adder/subtractor with store-end compare.
// ----------------------------------------------------------------------------
module rsp_alu #(
  parameter int PW          = 17,
  parameter int STORE_BYTES = 65536
) (
  input  logic [PW-1:0] a,
  input  logic [PW-1:0] b,
  input  logic          sub,
  output logic [PW:0]   sum,
  output logic          over
);

  always_comb begin
    if (sub) begin
      sum = {1'b0, a} - {1'b0, b};
    end else begin
      sum = {1'b0, a} + {1'b0, b};
    end
    over = (sum[PW-1:0] >= PW'(STORE_BYTES));
  end

endmodule

/* rtl/core/rsp_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsp_ctrl
// Command sequencer: loads, region checks and the byte-by-byte row walk.
// ----------------------------------------------------------------------------
module rsp_ctrl #(
  parameter int STORE_BYTES = 65536,
  parameter int MAX_REGIONS = 64,
  parameter int AW          = 16,
  parameter int PW          = 17,
  parameter int RIW         = 6
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  rsp_pkg::item_t    item,
  output logic              done,
  output rsp_pkg::result_t  result,
  input  logic              cfg_we,
  input  logic [6:0]        cfg_wdata,
  output logic              store_we,
  output logic [AW-1:0]     store_waddr,
  output logic [7:0]        store_wdata,
  output logic [AW-1:0]     store_raddr,
  input  logic [7:0]        store_rdata,
  output logic              tab_we,
  output logic [RIW-1:0]    tab_addr,
  output rsp_pkg::region_t  tab_wdata,
  input  rsp_pkg::region_t  tab_rdata,
  output logic [PW-1:0]     alu_a,
  output logic [PW-1:0]     alu_b,
  output logic              alu_sub,
  input  logic [PW:0]       alu_sum,
  input  logic              alu_over
);

  import rsp_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_WRAP  = 5'b00010,
    S_RLOAD = 5'b00100,
    S_WALK  = 5'b01000,
    S_PIXEL = 5'b10000
  } state_t;

  state_t      state, state_next;
  logic [6:0]  region_count;
  logic [PW-1:0] addr, addr_next;
  logic [7:0]  wbyte, wbyte_next;
  logic [9:0]  qx, qx_next;
  logic [9:0]  qy, qy_next;
  logic [PW-1:0] p, p_next;
  logic [9:0]  row, row_next;
  logic [9:0]  col, col_next;
  logic        done_next;
  result_t     result_next;

  logic        idx_ok;
  logic        skip;
  logic        transparent;
  logic [10:0] colsum;
  logic        hit;
  logic [9:0]  diff;
  logic [7:0]  inc;

  assign busy        = (state != S_IDLE);
  assign store_waddr = addr[AW-1:0];
  assign store_wdata = wbyte;
  assign store_raddr = alu_sum[AW-1:0];
  assign tab_addr    = item.region_index[RIW-1:0];
  assign tab_wdata   = '{width:  item.region_width,
                         height: item.region_height,
                         offset: item.region_offset};

  assign idx_ok      = ({1'b0, item.region_index} < region_count) &&
                       (int'(item.region_index) < MAX_REGIONS);
  assign skip        = (row < qy);
  assign transparent = store_rdata[RUN_TRANSPARENT_BIT];
  assign colsum      = {1'b0, col} + {4'b0, store_rdata[6:0] & RUN_MASK};
  assign hit         = ({1'b0, qx} < colsum);
  assign diff        = qx - col;

  always_comb begin
    state_next  = state;
    addr_next   = addr;
    wbyte_next  = wbyte;
    qx_next     = qx;
    qy_next     = qy;
    p_next      = p;
    row_next    = row;
    col_next    = col;
    done_next   = 1'b0;
    result_next = result;
    store_we    = 1'b0;
    tab_we      = 1'b0;
    alu_a       = p;
    alu_b       = '0;
    alu_sub     = 1'b0;
    inc         = 8'd1;
    case (state)
      S_IDLE: begin
        if (start) begin
          case (item.command)
            CMD_STORE_WRITE: begin
              addr_next  = PW'(item.store_address);
              wbyte_next = item.store_byte;
              state_next = S_WRAP;
            end
            CMD_REGION_WRITE: begin
              tab_we = (int'(item.region_index) < MAX_REGIONS);
            end
            CMD_QUERY: begin
              qx_next = item.pos_x;
              qy_next = item.pos_y;
              if (idx_ok) begin
                state_next = S_RLOAD;
              end else begin
                done_next   = 1'b1;
                result_next = '{pixel: 8'd0, status: ST_BAD_REGION};
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_WRAP: begin
        alu_a   = addr;
        alu_b   = PW'(STORE_BYTES);
        alu_sub = 1'b1;
        if (!alu_sum[PW]) begin
          addr_next = alu_sum[PW-1:0];
        end else begin
          store_we   = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_RLOAD: begin
        alu_a = PW'(tab_rdata.offset);
        if (({1'b0, qx} >= tab_rdata.width) || ({1'b0, qy} >= tab_rdata.height)) begin
          done_next   = 1'b1;
          result_next = '{pixel: 8'd0, status: ST_BAD_COORD};
          state_next  = S_IDLE;
        end else if (alu_over) begin
          done_next   = 1'b1;
          result_next = '{pixel: 8'd0, status: ST_BAD_DATA};
          state_next  = S_IDLE;
        end else begin
          p_next     = alu_sum[PW-1:0];
          row_next   = '0;
          col_next   = '0;
          state_next = S_WALK;
        end
      end
      S_WALK: begin
        if (skip) begin
          // rows above the queried one
          if (store_rdata == 8'd0 || transparent) begin
            inc = 8'd1;
          end else begin
            inc = store_rdata + 8'd1;
          end
          alu_b = PW'(inc);
          if (alu_over) begin
            done_next   = 1'b1;
            result_next = '{pixel: 8'd0, status: ST_BAD_DATA};
            state_next  = S_IDLE;
          end else begin
            p_next = alu_sum[PW-1:0];
            if (store_rdata == 8'd0) begin
              row_next = row + 10'd1;
            end
          end
        end else if (store_rdata == 8'd0) begin
          done_next   = 1'b1;
          result_next = '{pixel: 8'd0, status: ST_BAD_DATA};
          state_next  = S_IDLE;
        end else if (hit && transparent) begin
          done_next   = 1'b1;
          result_next = '{pixel: 8'd0, status: ST_OK};
          state_next  = S_IDLE;
        end else begin
          if (hit) begin
            inc = {1'b0, diff[6:0]} + 8'd1;
          end else if (transparent) begin
            inc = 8'd1;
          end else begin
            inc = {1'b0, store_rdata[6:0]} + 8'd1;
          end
          alu_b = PW'(inc);
          if (alu_over) begin
            done_next   = 1'b1;
            result_next = '{pixel: 8'd0, status: ST_BAD_DATA};
            state_next  = S_IDLE;
          end else if (hit) begin
            state_next = S_PIXEL;
          end else begin
            p_next   = alu_sum[PW-1:0];
            col_next = colsum[9:0];
          end
        end
      end
      S_PIXEL: begin
        done_next   = 1'b1;
        result_next = '{pixel: store_rdata, status: ST_OK};
        state_next  = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      region_count <= '0;
      done         <= 1'b0;
    end else begin
      state <= state_next;
      done  <= done_next;
      if (cfg_we) begin
        region_count <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    addr   <= addr_next;
    wbyte  <= wbyte_next;
    qx     <= qx_next;
    qy     <= qy_next;
    p      <= p_next;
    row    <= row_next;
    col    <= col_next;
    result <= result_next;
  end

endmodule

/* tb/rle_sprite_pixel_lookup_unit_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rle_sprite_pixel_lookup_unit_test
// Self-checking bench for the run-length sprite pixel lookup unit. Loads coded
// sprites and region entries, queries pixels under several region_count
// settings, and checks every result against a behavioral walk of the coded
// rows. Only queries whose walk touches loaded bytes and entries are issued.
// ----------------------------------------------------------------------------
module rle_sprite_pixel_lookup_unit_test;
  import rsp_pkg::*;

  localparam int DIM_MAX     = 1024;
  localparam int QUIET_LIMIT = 20000;
  localparam int PRINT_CAP   = 100;

  typedef struct {
    item_t   it;
    bit      yields;
    result_t want;
    bit      settle;
  } cmd_slot_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  item_t       item = '0;
  logic        done;
  result_t     result;
  logic        cfg_we = 1'b0;
  logic [6:0]  cfg_wdata = '0;

  cmd_slot_t   cmd_backlog[$];
  result_t     pixel_answers[$];

  logic [7:0]  store_img [0:STORE_BYTES_DEF-1];
  bit          store_set [0:STORE_BYTES_DEF-1];
  region_t     region_img [0:MAX_REGIONS_DEF-1];
  bit          region_set [0:MAX_REGIONS_DEF-1];
  int          region_lim = 0;
  int          queued_n = 0;
  int          fault_count = 0;
  bit          hold_next = 0;
  int          burst_left = 8;
  int          gap_left = 0;
  int          quiet = 0;

  rle_sprite_pixel_lookup_unit dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .item      (item),
    .done      (done),
    .result    (result),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // walks the coded rows; blind is set when the walk would read unloaded data
  function automatic void walk_lookup(input int unsigned idx, input int unsigned x,
                                      input int unsigned y, output logic [7:0] px,
                                      output status_t st, output bit blind);
    int unsigned p, q, row, col, run;
    logic [7:0] b;
    px = '0;
    st = ST_OK;
    blind = 1'b0;
    row = 0;
    col = 0;
    if (idx >= region_lim || idx >= MAX_REGIONS_DEF) begin
      st = ST_BAD_REGION;
      return;
    end
    if (!region_set[idx]) begin
      blind = 1'b1;
      return;
    end
    if (x >= region_img[idx].width || y >= region_img[idx].height) begin
      st = ST_BAD_COORD;
      return;
    end
    p = region_img[idx].offset;
    while (row < y) begin
      if (p >= STORE_BYTES_DEF) begin
        st = ST_BAD_DATA;
        return;
      end
      if (!store_set[p]) begin
        blind = 1'b1;
        return;
      end
      b = store_img[p];
      if (b == 8'd0) begin
        p++;
        row++;
      end else if (b[RUN_TRANSPARENT_BIT]) begin
        p++;
      end else begin
        p = p + b + 1;
      end
    end
    while (1) begin
      if (p >= STORE_BYTES_DEF) begin
        st = ST_BAD_DATA;
        return;
      end
      if (!store_set[p]) begin
        blind = 1'b1;
        return;
      end
      b = store_img[p];
      if (b == 8'd0) begin
        st = ST_BAD_DATA;
        return;
      end
      run = b[6:0] & RUN_MASK;
      if (x < col + run) begin
        if (b[RUN_TRANSPARENT_BIT]) return;
        q = p + 1 + (x - col);
        if (q >= STORE_BYTES_DEF) begin
          st = ST_BAD_DATA;
          return;
        end
        if (!store_set[q]) begin
          blind = 1'b1;
          return;
        end
        px = store_img[q];
        return;
      end
      p = b[RUN_TRANSPARENT_BIT] ? p + 1 : p + run + 1;
      col = col + run;
    end
  endfunction

  function automatic item_t rand_item(input cmd_t c);
    item_t it;
    it.command       = c;
    it.store_address = 16'($urandom);
    it.store_byte    = 8'($urandom);
    it.region_index  = 6'($urandom);
    it.region_width  = 11'($urandom_range(0, DIM_MAX));
    it.region_height = 11'($urandom_range(0, DIM_MAX));
    it.region_offset = 16'($urandom);
    it.pos_x         = 10'($urandom);
    it.pos_y         = 10'($urandom);
    return it;
  endfunction

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    if (fault_count < PRINT_CAP)
      $display("%0t ERROR %s: got %h, want %h", $time, what, got, want);
    fault_count++;
  endtask

  // applies the item to the shadow state and queues it with its answer
  task automatic queue_item(input item_t it);
    cmd_slot_t  e;
    logic [7:0] px;
    status_t    st;
    bit         blind;
    e.it = it;
    e.yields = 1'b0;
    e.want = '0;
    e.settle = hold_next || ($urandom_range(0, 199) == 0);
    case (it.command)
      CMD_STORE_WRITE: begin
        store_img[it.store_address] = it.store_byte;
        store_set[it.store_address] = 1'b1;
      end
      CMD_REGION_WRITE: begin
        region_img[it.region_index].width  = it.region_width;
        region_img[it.region_index].height = it.region_height;
        region_img[it.region_index].offset = it.region_offset;
        region_set[it.region_index] = 1'b1;
      end
      CMD_QUERY: begin
        walk_lookup(it.region_index, it.pos_x, it.pos_y, px, st, blind);
        if (blind) return;
        e.yields = 1'b1;
        e.want.pixel = px;
        e.want.status = st;
      end
      default: ;
    endcase
    hold_next = 1'b0;
    cmd_backlog.push_back(e);
    queued_n++;
  endtask

  task automatic put_byte(input int addr, input int val);
    item_t it;
    it = rand_item(CMD_STORE_WRITE);
    it.store_address = addr[15:0];
    it.store_byte = val[7:0];
    queue_item(it);
  endtask

  task automatic put_region(input int idx, input int w, input int h, input int off);
    item_t it;
    it = rand_item(CMD_REGION_WRITE);
    it.region_index = idx[5:0];
    it.region_width = w[10:0];
    it.region_height = h[10:0];
    it.region_offset = off[15:0];
    queue_item(it);
  endtask

  task automatic ask(input int idx, input int x, input int y);
    item_t it;
    it = rand_item(CMD_QUERY);
    it.region_index = idx[5:0];
    it.pos_x = x[9:0];
    it.pos_y = y[9:0];
    queue_item(it);
  endtask

  // region entry, coded rows and a handful of queries on them
  task automatic draw_sprite(input int idx);
    int w, h, off, k, r, rem, n, j, q, nq, x, y;
    bit wide, cut;
    wide = ($urandom_range(0, 19) == 0);
    w = wide ? $urandom_range(900, DIM_MAX) : $urandom_range(1, 12);
    h = wide ? $urandom_range(1, 3) : $urandom_range(1, 4);
    off = ($urandom_range(0, 9) == 0) ? $urandom_range(65500, 65535) : $urandom_range(0, 65535);
    put_region(idx, w, h, off);
    k = 0;
    for (r = 0; r < h; r++) begin
      rem = w;
      cut = ($urandom_range(0, 19) == 0);
      while (rem > 0 && !(cut && $urandom_range(0, 2) == 0)) begin
        if (wide || $urandom_range(0, 1) == 1) begin
          n = $urandom_range(0, rem < 127 ? rem : 127);
          put_byte(off + k, 8'h80 | n);
          k++;
        end else begin
          n = $urandom_range(1, rem < 8 ? rem : 8);
          put_byte(off + k, n);
          k++;
          for (j = 0; j < n; j++) begin
            put_byte(off + k, $urandom_range(0, 255));
            k++;
          end
        end
        rem -= n;
      end
      put_byte(off + k, 0);
      k++;
    end
    nq = $urandom_range(3, 8);
    for (q = 0; q < nq; q++) begin
      x = $urandom_range(0, w < DIM_MAX ? w : DIM_MAX - 1);
      y = $urandom_range(0, h);
      ask(idx, x, y);
    end
  endtask

  task automatic fill_phase(input int budget);
    int stop, lim_eff, idx, pick;
    stop = queued_n + budget;
    lim_eff = region_lim > MAX_REGIONS_DEF ? MAX_REGIONS_DEF : region_lim;
    while (queued_n < stop) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        idx = (lim_eff > 0 && $urandom_range(0, 9) != 0) ?
              $urandom_range(0, lim_eff - 1) : $urandom_range(0, MAX_REGIONS_DEF - 1);
        draw_sprite(idx);
      end else if (pick < 85) begin
        queue_item(rand_item(CMD_QUERY));
      end else begin
        queue_item(rand_item(cmd_t'($urandom_range(0, 3))));
      end
    end
  endtask

  task automatic wait_drained();
    while (cmd_backlog.size() != 0 || pixel_answers.size() != 0) @(posedge clk);
  endtask

  task automatic set_region_count(input int v);
    wait_drained();
    while (busy) @(posedge clk);
    repeat (8) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v[6:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    region_lim = v & 127;
  endtask

  // driver: one transfer per edge with start high and busy low
  always @(posedge clk) begin : drive
    cmd_slot_t nx;
    bit go;
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        nx = cmd_backlog.pop_front();
        if (nx.yields) pixel_answers.push_back(nx.want);
      end
      go = 1'b0;
      if (start && busy) begin
        go = 1'b1;
      end else if (gap_left > 0) begin
        gap_left--;
      end else if (cmd_backlog.size() > 0 &&
                   !(cmd_backlog[0].settle && pixel_answers.size() > 0)) begin
        go = 1'b1;
        item <= cmd_backlog[0].it;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300) :
                       $urandom_range(1, 20);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
        end
      end
      start <= go;
    end
  end

  // monitor and watchdog
  always @(posedge clk) begin : watch
    result_t w;
    if (!rst) begin
      if (done) begin
        if (pixel_answers.size() == 0) begin
          report_mismatch("result with none due", result.pixel, 8'h00);
        end else begin
          w = pixel_answers.pop_front();
          if (result.pixel !== w.pixel) report_mismatch("pixel", result.pixel, w.pixel);
          if (result.status !== w.status)
            report_mismatch("status", 8'(result.status), 8'(w.status));
        end
      end
      if ((start && !busy) || done) quiet = 0;
      else quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("rle_sprite_pixel_lookup_unit: mismatch");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int lims [6];
    int p;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    set_region_count(0);

    // no valid region yet, unused command
    ask(0, 0, 0);
    queue_item(rand_item(CMD_NONE));
    // region whose walk runs off the store end
    put_byte(16'hFFFE, 0);
    put_byte(16'hFFFF, 0);
    put_region(0, DIM_MAX, DIM_MAX, 16'hFFFE);
    put_region(1, 0, 0, 0);
    // full-width transparent row, then empty run and one literal pixel
    for (p = 0; p < 8; p++) put_byte(16'h1000 + p, 8'hFF);
    put_byte(16'h1008, 8'h88);
    put_byte(16'h1009, 8'h00);
    put_byte(16'h100A, 8'h80);
    put_byte(16'h100B, 8'h01);
    put_byte(16'h100C, 8'hFF);
    put_byte(16'h100D, 8'h00);
    put_region(MAX_REGIONS_DEF - 1, DIM_MAX, 2, 16'h1000);

    set_region_count(MAX_REGIONS_DEF);
    ask(0, 0, DIM_MAX - 1);
    ask(MAX_REGIONS_DEF - 1, DIM_MAX - 1, 0);
    ask(MAX_REGIONS_DEF - 1, 0, 1);
    ask(MAX_REGIONS_DEF - 1, 1, 1);
    ask(1, 0, 0);
    ask(MAX_REGIONS_DEF - 1, 0, 2);

    lims = '{MAX_REGIONS_DEF, 0, 127, 1, MAX_REGIONS_DEF, 0};
    lims[1] = $urandom_range(2, 63);
    lims[5] = $urandom_range(1, 40);
    for (p = 0; p < 6; p++) begin
      set_region_count(lims[p]);
      hold_next = 1'b1;
      fill_phase(280);
    end

    wait_drained();
    repeat (50) @(posedge clk);
    if (fault_count == 0) begin
      $display("rle_sprite_pixel_lookup_unit: match");
    end else begin
      $display("rle_sprite_pixel_lookup_unit: mismatch");
    end
    $finish;
  end

endmodule
